### design/pidrm_pkg.sv
package pidrm_pkg;

	// Field widths of the item channels
	localparam int CMD_W     = 2;
	localparam int SYSNO_W   = 12;
	localparam int VALUE_W   = 32;
	localparam int CHILD_W   = 22;
	localparam int KEY_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_CALLS = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_STOP  = 2'd0,
		CMD_CHILD = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GETPID  = 3'd0,
		REG_GETPPID = 3'd1,
		REG_GETTID  = 3'd2,
		REG_GETPGID = 3'd3,
		REG_GETSID  = 3'd4
	} reg_idx_t;

	localparam logic [SYSNO_W-1:0] CALL_RESET [NUM_CALLS] = '{
		12'd39, 12'd110, 12'd186, 12'd121, 12'd124
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT
	} top_state_t;

	typedef enum logic {
		LK_IDLE,
		LK_SCAN
	} lk_state_t;

	// Request from the control logic to the lookup engine
	typedef struct packed {
		logic             start;
		logic             clear;
		logic [KEY_W-1:0] key;
	} lk_req_t;

	// Completion report of the lookup engine
	typedef struct packed {
		logic done;
		logic full;
	} lk_rsp_t;

endpackage

### design/pidrm_ifs.sv
interface pidrm_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [pidrm_pkg::CMD_W-1:0]            command;
	logic [pidrm_pkg::SYSNO_W-1:0]          syscall_number;
	logic signed [pidrm_pkg::VALUE_W-1:0]   return_value;
	logic [pidrm_pkg::CHILD_W-1:0]          new_child_id;

	modport source (output valid, command, syscall_number, return_value, new_child_id,
		input ready);
	modport sink (input valid, command, syscall_number, return_value, new_child_id,
		output ready);
endinterface

interface pidrm_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pidrm_pkg::VALUE_W-1:0]   result_value;
	logic                                   rewritten;
	logic                                   table_full;
	logic                                   exit_stop;

	modport source (output valid, result_value, rewritten, table_full, exit_stop,
		input ready);
	modport sink (input valid, result_value, rewritten, table_full, exit_stop,
		output ready);
endinterface

interface pidrm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pidrm_pkg::CFG_IDX_W-1:0]   index;
	logic [pidrm_pkg::SYSNO_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/process_id_remap_table.sv
// Process identifier remap table. Each input item is a syscall stop, a
// new-child announcement, a table clear or an unused command, and each
// yields exactly one result item. Syscall stops alternate between entry
// and exit; on an exit stop whose number equals one of the five identity
// calls held in the configuration registers, a positive return value is
// replaced by its virtual identifier (its position in the table plus one),
// and a new child is likewise given the next free virtual identifier. The
// identifiers live in a single-port-read, single-port-write memory of
// TABLE_DEPTH entries that is searched from the start, one entry per cycle.
// An item that needs no search goes from acceptance through the emit state
// into the output register; an item that searches passes through the
// lookup state first, and the search ends at a hit or once every filled
// entry has been compared. The block then returns to idle to take the next
// item, so it handles one item at a time; a result that the consumer has
// not yet taken holds the next one back, and the input waits for as long as
// that lasts. The memory needs no clearing after reset: only entries below
// the fill count are ever read.
// When the table is full the real value passes through and table_full is
// set. Configuration writes are accepted at any time but must only be
// issued while the block is idle; a write to an index beyond the five
// registers is accepted and ignored.
module process_id_remap_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	pidrm_req_if.sink    req,
	pidrm_rsp_if.source  rsp,
	pidrm_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Control state
	pidrm_pkg::top_state_t state_q;
	pidrm_pkg::top_state_t state_d;
	logic                  inside_q;
	logic                  out_valid_q;

	// Identity call numbers, written through the configuration channel
	logic [pidrm_pkg::SYSNO_W-1:0] call_q [pidrm_pkg::NUM_CALLS];

	// Result under construction, then the output register that holds it
	// until the consumer takes it.
	logic signed [pidrm_pkg::VALUE_W-1:0] res_value_q;
	logic                                 res_rew_q;
	logic                                 res_full_q;
	logic                                 res_exit_q;
	logic                                 lk_stop_q;
	logic signed [pidrm_pkg::VALUE_W-1:0] out_value_q;
	logic                                 out_rew_q;
	logic                                 out_full_q;
	logic                                 out_exit_q;

	pidrm_pkg::lk_req_t lk_req;
	pidrm_pkg::lk_rsp_t lk_rsp;
	logic [CNT_W-1:0]   lk_vid;

	logic accept;
	logic call_match;
	logic ret_positive;
	logic is_stop;
	logic is_child;
	logic stop_lookup;
	logic child_lookup;
	logic load_out;

	// Decode of the incoming item. A lookup is needed for an exit stop of a
	// matching call with a positive return value, or for a non-zero child.
	always_comb begin
		call_match = 1'b0;
		for (int k = 0; k < pidrm_pkg::NUM_CALLS; k++) begin
			if (call_q[k] == req.syscall_number) begin
				call_match = 1'b1;
			end
		end
		ret_positive = (req.return_value > 0);
		is_stop      = (req.command == pidrm_pkg::CMD_STOP);
		is_child     = (req.command == pidrm_pkg::CMD_CHILD);
		stop_lookup  = is_stop && inside_q && call_match && ret_positive;
		child_lookup = is_child && (req.new_child_id != '0);
	end

	// Next state and handshake
	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		load_out     = 1'b0;
		lk_req.start = 1'b0;
		lk_req.clear = 1'b0;
		lk_req.key   = is_child ? pidrm_pkg::KEY_W'(req.new_child_id)
			: req.return_value[pidrm_pkg::KEY_W-1:0];
		accept       = 1'b0;
		case (state_q)
			pidrm_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				accept    = req.valid;
				if (req.valid) begin
					lk_req.clear = (req.command == pidrm_pkg::CMD_CLEAR);
					if (stop_lookup || child_lookup) begin
						lk_req.start = 1'b1;
						state_d      = pidrm_pkg::ST_LOOKUP;
					end else begin
						state_d = pidrm_pkg::ST_EMIT;
					end
				end
			end
			pidrm_pkg::ST_LOOKUP: begin
				if (lk_rsp.done) begin
					state_d = pidrm_pkg::ST_EMIT;
				end
			end
			pidrm_pkg::ST_EMIT: begin
				// The output register is free, or is being emptied this cycle.
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = pidrm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pidrm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidrm_pkg::ST_IDLE;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < pidrm_pkg::NUM_CALLS; k++) begin
				call_q[k] <= pidrm_pkg::CALL_RESET[k];
			end
		end else begin
			state_q <= state_d;
			if (accept && is_stop) begin
				inside_q <= !inside_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid && (cfg.index < pidrm_pkg::CFG_IDX_W'(pidrm_pkg::NUM_CALLS))) begin
				call_q[cfg.index] <= cfg.data;
			end
		end
	end

	// Result fields. At acceptance the pass-through outcome is recorded; a
	// lookup then either substitutes the virtual identifier or flags a full
	// table, leaving the real value in place.
	always_ff @(posedge clk) begin
		if (accept) begin
			lk_stop_q  <= is_stop;
			res_rew_q  <= 1'b0;
			res_full_q <= 1'b0;
			res_exit_q <= is_stop && inside_q;
			if (is_stop) begin
				res_value_q <= req.return_value;
			end else if (is_child) begin
				res_value_q <= pidrm_pkg::VALUE_W'(req.new_child_id);
			end else begin
				res_value_q <= '0;
			end
		end else if ((state_q == pidrm_pkg::ST_LOOKUP) && lk_rsp.done) begin
			if (lk_rsp.full) begin
				res_full_q <= 1'b1;
			end else begin
				res_value_q <= pidrm_pkg::VALUE_W'(lk_vid);
				res_rew_q   <= lk_stop_q;
			end
		end
		if (load_out) begin
			out_value_q <= res_value_q;
			out_rew_q   <= res_rew_q;
			out_full_q  <= res_full_q;
			out_exit_q  <= res_exit_q;
		end
	end

	pidrm_lookup #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lk_req),
		.rsp    (lk_rsp),
		.vid    (lk_vid)
	);

	assign cfg.ready        = 1'b1;
	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.rewritten    = out_rew_q;
	assign rsp.table_full   = out_full_q;
	assign rsp.exit_stop    = out_exit_q;

endmodule

### design/pidrm_lookup.sv
// Lookup engine: scans the identifier memory one entry per cycle and
// appends the key when it is not found and a free entry remains.
module pidrm_lookup #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pidrm_pkg::lk_req_t                    req,
	output pidrm_pkg::lk_rsp_t                    rsp,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]      vid
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [pidrm_pkg::KEY_W-1:0] mem [TABLE_DEPTH];

	pidrm_pkg::lk_state_t        state_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            issue_q;
	logic [pidrm_pkg::KEY_W-1:0] key_q;
	logic                        cmp_vld_s1;
	logic [IDX_W-1:0]            cmp_idx_s1;
	logic [pidrm_pkg::KEY_W-1:0] rdata_s1;

	logic scanning;
	logic hit;
	logic last_cmp;
	logic do_read;
	logic finish_hit;
	logic finish_miss;
	logic do_insert;

	always_comb begin
		scanning    = (state_q == pidrm_pkg::LK_SCAN);
		hit         = cmp_vld_s1 && (rdata_s1 == key_q);
		last_cmp    = cmp_vld_s1 && (CNT_W'(cmp_idx_s1) == count_q - CNT_W'(1));
		do_read     = scanning && !hit && (issue_q < count_q);
		finish_hit  = scanning && hit;
		finish_miss = scanning && !hit && ((count_q == '0) || last_cmp);
		do_insert   = finish_miss && (count_q != DEPTH_C);
		rsp.done    = finish_hit || finish_miss;
		rsp.full    = finish_miss && !do_insert;
		vid         = finish_hit ? CNT_W'(cmp_idx_s1) + CNT_W'(1) : count_q + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pidrm_pkg::LK_IDLE;
			count_q    <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= do_read;
			if (req.clear) begin
				count_q <= '0;
			end else if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			case (state_q)
				pidrm_pkg::LK_IDLE: begin
					if (req.start) begin
						state_q <= pidrm_pkg::LK_SCAN;
					end
				end
				pidrm_pkg::LK_SCAN: begin
					if (finish_hit || finish_miss) begin
						state_q <= pidrm_pkg::LK_IDLE;
					end
				end
				default: begin
					state_q <= pidrm_pkg::LK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			key_q   <= req.key;
			issue_q <= '0;
		end else if (do_read) begin
			issue_q <= issue_q + CNT_W'(1);
		end
		cmp_idx_s1 <= issue_q[IDX_W-1:0];
	end

	// Memory: one read port, one write port, registered read data.
	always_ff @(posedge clk) begin
		if (do_read) begin
			rdata_s1 <= mem[issue_q[IDX_W-1:0]];
		end
		if (do_insert) begin
			mem[count_q[IDX_W-1:0]] <= key_q;
		end
	end

endmodule

### design/pidrm_checker.sv
// Checks on the result channel of the remap table.
module pidrm_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input logic signed [pidrm_pkg::VALUE_W-1:0] result_value,
	input logic                                 rewritten,
	input logic                                 table_full,
	input logic                                 exit_stop
);

	// A rewrite only happens on an exit stop, and never together with a full table.
	a_rewrite_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rewritten |-> exit_stop && !table_full)
		else $error("rewritten result without exit stop or with full table");

	// A rewritten value is a virtual identifier within the table.
	a_rewrite_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rewritten |-> (result_value > 0) && (result_value <= TABLE_DEPTH))
		else $error("virtual identifier out of range");

	// A full table on a syscall stop is only reported for a positive return value.
	a_full_positive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && table_full && exit_stop |-> (result_value > 0))
		else $error("full table reported for a non-positive return value");

	// A stalled result is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value))
		else $error("result changed while stalled");

endmodule

bind process_id_remap_table pidrm_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_pidrm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.result_value (rsp.result_value),
	.rewritten    (rsp.rewritten),
	.table_full   (rsp.table_full),
	.exit_stop    (rsp.exit_stop)
);

### bench/remap_tracker_pkg.sv
`timescale 1ns / 1ps

package remap_tracker_pkg;
	import pidrm_pkg::*;

	localparam int ID_TABLE_DEPTH = 64;

	// An index beyond the five call registers; the block accepts and ignores it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               rewritten;
		logic               table_full;
		logic               exit_stop;
	} remap_result_t;

	class id_remap_tracker;
		logic [SYSNO_W-1:0] call_no [NUM_CALLS];
		logic [KEY_W-1:0]   real_ids [ID_TABLE_DEPTH];
		int unsigned        fill;
		bit                 in_call;
		remap_result_t      pending_results [$];
		int unsigned        errors;

		function new();
			foreach (call_no[k])
				call_no[k] = CALL_RESET[k];
			fill = 0;
			in_call = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SYSNO_W-1:0] data);
			if (idx < NUM_CALLS)
				call_no[idx] = data;
		endfunction

		// Virtual id of key, inserting it when absent; zero when no entry is free.
		function int unsigned virtual_id(logic [KEY_W-1:0] key);
			for (int k = 0; k < fill; k++)
				if (real_ids[k] == key)
					return k + 1;
			if (fill >= ID_TABLE_DEPTH)
				return 0;
			real_ids[fill] = key;
			fill++;
			return fill;
		endfunction

		function void note_item(cmd_t cmd, logic [SYSNO_W-1:0] sysno,
				logic [VALUE_W-1:0] rv, logic [CHILD_W-1:0] child);
			remap_result_t r;
			int unsigned   vid;
			bit            hit;
			r.value = '0;
			r.rewritten = 1'b0;
			r.table_full = 1'b0;
			r.exit_stop = 1'b0;
			hit = 1'b0;
			case (cmd)
				CMD_STOP: begin
					r.value = rv;
					if (!in_call) begin
						in_call = 1'b1;
					end else begin
						in_call = 1'b0;
						r.exit_stop = 1'b1;
						foreach (call_no[k])
							if (call_no[k] == sysno)
								hit = 1'b1;
						if (hit && rv != '0 && !rv[VALUE_W-1]) begin
							vid = virtual_id(rv[KEY_W-1:0]);
							if (vid == 0) begin
								r.table_full = 1'b1;
							end else begin
								r.value = vid;
								r.rewritten = 1'b1;
							end
						end
					end
				end
				CMD_CHILD: begin
					if (child != '0) begin
						vid = virtual_id(KEY_W'(child));
						if (vid == 0) begin
							r.table_full = 1'b1;
							r.value = VALUE_W'(child);
						end else begin
							r.value = vid;
						end
					end
				end
				CMD_CLEAR: fill = 0;
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [VALUE_W-1:0] value, logic rewritten, logic table_full,
				logic exit_stop);
			remap_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result value %h with no item outstanding", value));
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value)
					report($sformatf("result_value %h, expected %h", value, want.value));
				if (rewritten !== want.rewritten)
					report($sformatf("rewritten %b, expected %b", rewritten, want.rewritten));
				if (table_full !== want.table_full)
					report($sformatf("table_full %b, expected %b", table_full, want.table_full));
				if (exit_stop !== want.exit_stop)
					report($sformatf("exit_stop %b, expected %b", exit_stop, want.exit_stop));
			end
		endtask
	endclass

endpackage

### bench/tb_process_id_remap_table.sv
`timescale 1ns / 1ps

module tb_process_id_remap_table;
	import pidrm_pkg::*;
	import remap_tracker_pkg::*;

	// Length of the deliberate receiver hold-off, in clock cycles.
	localparam int HOLD_CYCLES = 300;
	// A search of a full table plus the fixed pipeline cycles.
	localparam int SETTLE_CYCLES = ID_TABLE_DEPTH + 4;
	// Upper bound on waiting for outstanding results to drain.
	localparam int DRAIN_LIMIT = 20000;
	localparam int POOL_SIZE = 32;

	logic clk = 1'b0;
	logic arst_n;

	// When set, neither side inserts idle cycles.
	bit no_idle;
	// Set by the stimulus to make the receiver hold off for a long stretch.
	bit hold_request;

	// Recently used real identifiers, so that lookups hit existing entries.
	logic [CHILD_W-1:0] id_pool [$];

	id_remap_tracker tracker;

	pidrm_req_if req_ch ();
	pidrm_rsp_if rsp_ch ();
	pidrm_cfg_if cfg_ch ();

	process_id_remap_table #(
		.TABLE_DEPTH(ID_TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// Draws a fresh nonzero identifier and remembers it for later reuse.
	function automatic logic [CHILD_W-1:0] fresh_id();
		logic [CHILD_W-1:0] id;
		id = CHILD_W'($urandom_range(1, 2 ** CHILD_W - 1));
		id_pool.push_back(id);
		if (id_pool.size() > POOL_SIZE)
			void'(id_pool.pop_front());
		return id;
	endfunction

	function automatic logic [CHILD_W-1:0] pooled_id();
		if (id_pool.size() == 0)
			return fresh_id();
		return id_pool[$urandom_range(0, id_pool.size() - 1)];
	endfunction

	// Mostly one of the configured identity calls, otherwise any number.
	function automatic logic [SYSNO_W-1:0] pick_sysno();
		if ($urandom_range(0, 99) < 75)
			return tracker.call_no[$urandom_range(0, NUM_CALLS - 1)];
		return SYSNO_W'($urandom());
	endfunction

	// Return values: known identifiers, fresh ones, wide random values, and the
	// boundaries of the positive range (zero, largest positive, negatives).
	function automatic logic [VALUE_W-1:0] pick_return();
		int unsigned w;
		w = $urandom_range(0, 99);
		if (w < 30)
			return VALUE_W'(pooled_id());
		if (w < 55)
			return VALUE_W'(fresh_id());
		if (w < 80)
			return VALUE_W'($urandom());
		if (w < 85)
			return '0;
		if (w < 90)
			return 32'h7FFF_FFFF;
		if (w < 95)
			return 32'h8000_0000;
		return 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 100));
	endfunction

	function automatic logic [CHILD_W-1:0] pick_child();
		int unsigned w;
		w = $urandom_range(0, 99);
		if (w < 10)
			return '0;
		if (w < 40)
			return pooled_id();
		if (w < 45)
			return {CHILD_W{1'b1}};
		return fresh_id();
	endfunction

	// Offers one item at the falling edge and holds it until the block takes it.
	// Returns at the falling edge after acceptance, with valid still high so that
	// back-to-back items need no second assignment in the same time step.
	task automatic send_item(cmd_t cmd, logic [SYSNO_W-1:0] sysno,
			logic [VALUE_W-1:0] rv, logic [CHILD_W-1:0] child);
		while (!no_idle && $urandom_range(0, 99) < 14) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.syscall_number <= sysno;
		req_ch.return_value <= rv;
		req_ch.new_child_id <= child;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_item(cmd, sysno, rv, child);
		@(negedge clk);
	endtask

	// A complete syscall: an entry stop is sent first unless the block is
	// already inside a call, then the exit stop that may be rewritten.
	task automatic send_call(logic [SYSNO_W-1:0] sysno, logic [VALUE_W-1:0] rv);
		if (!tracker.in_call)
			send_item(CMD_STOP, pick_sysno(), VALUE_W'($urandom()), CHILD_W'($urandom()));
		send_item(CMD_STOP, sysno, rv, CHILD_W'($urandom()));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SYSNO_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		tracker.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Drops the request valid, waits until every expected result has come back
	// and then lets the block's worst-case latency pass.
	task automatic settle();
		int unsigned waited;
		waited = 0;
		req_ch.valid <= 1'b0;
		while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Programs all five identity calls while the block is idle, plus a write to
	// an unused index which must change nothing.
	task automatic load_calls(logic [SYSNO_W-1:0] pid, logic [SYSNO_W-1:0] ppid,
			logic [SYSNO_W-1:0] tid, logic [SYSNO_W-1:0] pgid, logic [SYSNO_W-1:0] sid);
		settle();
		write_reg(REG_GETPID, pid);
		write_reg(REG_GETPPID, ppid);
		write_reg(REG_GETTID, tid);
		write_reg(REG_GETPGID, pgid);
		write_reg(REG_GETSID, sid);
		write_reg(REG_SPARE, SYSNO_W'($urandom()));
		cfg_ch.valid <= 1'b0;
	endtask

	// Random traffic, dominated by well-formed syscalls and child announcements,
	// with lone stops to upset the entry/exit pairing and the odd clear or
	// unused command.
	task automatic run_random(int count);
		int unsigned w;
		repeat (count) begin
			w = $urandom_range(0, 99);
			if (w < 55) begin
				send_call(pick_sysno(), pick_return());
			end else if (w < 82) begin
				send_item(CMD_CHILD, SYSNO_W'($urandom()), VALUE_W'($urandom()), pick_child());
			end else if (w < 94) begin
				send_item(CMD_STOP, pick_sysno(), pick_return(), CHILD_W'($urandom()));
			end else if (w < 97) begin
				send_item(CMD_CLEAR, SYSNO_W'($urandom()), VALUE_W'($urandom()),
					CHILD_W'($urandom()));
			end else begin
				send_item(CMD_RSVD, SYSNO_W'($urandom()), VALUE_W'($urandom()),
					CHILD_W'($urandom()));
			end
		end
	endtask

	// Fills the table past its capacity with new children, then tries both
	// insert paths on the full table, along with a lookup of a recently used identifier.
	task automatic fill_burst();
		repeat (ID_TABLE_DEPTH + 6)
			send_item(CMD_CHILD, SYSNO_W'($urandom()), VALUE_W'($urandom()), fresh_id());
		repeat (4)
			send_call(tracker.call_no[$urandom_range(0, NUM_CALLS - 1)], VALUE_W'(fresh_id()));
		send_item(CMD_CHILD, '0, '0, pooled_id());
	endtask

	// The receiver changes ready at falling edges only. A hold-off request keeps
	// it low for a counted stretch while the sender carries on offering items.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 14);
		end
	end

	// Results are taken at the rising edge, where the handshake completes.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_result(rsp_ch.result_value, rsp_ch.rewritten, rsp_ch.table_full,
				rsp_ch.exit_stop);
	end

	initial begin
		tracker = new();
		no_idle = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_STOP;
		req_ch.syscall_number = '0;
		req_ch.return_value = '0;
		req_ch.new_child_id = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_GETPID;
		cfg_ch.data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with the registers at their reset values. An unused
		// command and an empty child announcement must leave everything alone.
		send_item(CMD_RSVD, '1, '1, '1);
		send_item(CMD_CHILD, '0, '0, '0);
		// New children get 1 and 2; the first is then found again.
		send_item(CMD_CHILD, '0, '0, 22'd1);
		send_item(CMD_CHILD, '0, '0, {CHILD_W{1'b1}});
		send_item(CMD_CHILD, '0, '0, 22'd1);
		// Each identity call in turn, entry then exit.
		send_item(CMD_STOP, CALL_RESET[REG_GETPID], 32'd1234, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETPID], 32'd1234, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETPPID], 32'h7FFF_FFFF, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETPPID], 32'h7FFF_FFFF, '0);
		// A zero or negative return on a matching exit passes unchanged.
		send_item(CMD_STOP, CALL_RESET[REG_GETTID], 32'd0, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETTID], 32'd0, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETPGID], 32'hFFFF_FFFF, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETPGID], 32'hFFFF_FFFF, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETSID], 32'h8000_0000, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETSID], 32'h8000_0000, '0);
		// A return value already known from a child announcement.
		send_item(CMD_STOP, CALL_RESET[REG_GETSID], 32'd1, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETSID], 32'd1, '0);
		// An exit stop of a call that is not an identity call.
		send_item(CMD_STOP, '1, 32'd555, '0);
		send_item(CMD_STOP, '1, 32'd555, '0);
		// Clear restarts numbering from 1.
		send_item(CMD_CLEAR, '0, '0, '0);
		send_item(CMD_CHILD, '0, '0, {CHILD_W{1'b1}});
		// A clear between entry and exit keeps the block inside the call.
		send_item(CMD_STOP, CALL_RESET[REG_GETPID], 32'd77, '0);
		send_item(CMD_CLEAR, '0, '0, '0);
		send_item(CMD_STOP, CALL_RESET[REG_GETPID], 32'd77, '0);
		run_random(30);

		// Extreme register values, with a stretch in which neither side idles,
		// and then the table driven full.
		load_calls('0, '1, 12'h555, 12'hAAA, 12'd1);
		no_idle = 1'b1;
		run_random(45);
		no_idle = 1'b0;
		fill_burst();

		// Random registers; the receiver holds off for a long stretch while
		// items keep coming, so the block backs up and stalls its input.
		load_calls(SYSNO_W'($urandom()), SYSNO_W'($urandom()), SYSNO_W'($urandom()),
			SYSNO_W'($urandom()), SYSNO_W'($urandom()));
		hold_request = 1'b1;
		run_random(45);

		// The opposite extremes, and the table driven full once more.
		load_calls('1, '0, 12'hAAA, 12'h555, 12'd4094);
		run_random(45);
		fill_burst();

		// Back to the reset values.
		load_calls(CALL_RESET[REG_GETPID], CALL_RESET[REG_GETPPID], CALL_RESET[REG_GETTID],
			CALL_RESET[REG_GETPGID], CALL_RESET[REG_GETSID]);
		run_random(45);

		settle();
		if (tracker.pending_results.size() != 0)
			tracker.report($sformatf("%0d results never arrived",
				tracker.pending_results.size()));
		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a block that hangs.
	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
design/pidrm_pkg.sv
design/pidrm_ifs.sv
design/pidrm_lookup.sv
design/process_id_remap_table.sv
design/pidrm_checker.sv
bench/remap_tracker_pkg.sv
bench/tb_process_id_remap_table.sv
